// ===== src/dtcr_pkg.sv =====
package dtcr_pkg;

    // Divider operand widths: scaled numerator, depth term, quotient magnitude
    localparam int DIV_NW = 38;
    localparam int DIV_DW = 25;
    localparam int DIV_QW = 16;
    // Register stages through the divider, input capture and output saturation included
    localparam int DIV_LAT = DIV_QW + 2;

    // Configuration register indexes
    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Inverse color intrinsics, Q2.24
    localparam logic signed [25:0] K11 = 26'sd31692;
    localparam logic signed [25:0] K13 = -26'sd10428046;
    localparam logic signed [25:0] K22 = 26'sd31922;
    localparam logic signed [25:0] K23 = -26'sd8537925;

    // Color-to-depth pose rotation, Q2.24
    localparam logic signed [25:0] P11 = 26'sd16774632;
    localparam logic signed [25:0] P12 = -26'sd24797;
    localparam logic signed [25:0] P21 = 26'sd21190;
    localparam logic signed [25:0] P22 = 26'sd16775941;
    localparam logic signed [25:0] P31 = -26'sd293383;
    localparam logic signed [25:0] P32 = -26'sd205543;

    // Translation plus unit z column, moved to Q.48, with the half for round-half-up
    localparam logic signed [51:0] PX_OFS = (-52'sd38923 <<< 24) + (52'sd1 <<< 23);
    localparam logic signed [51:0] PY_OFS = (52'sd2045160 <<< 24) + (52'sd1 <<< 23);
    localparam logic signed [51:0] PZ_OFS = (52'sd16962202 <<< 24) + (52'sd1 <<< 23);

    // Depth intrinsics, Q24.24
    localparam logic signed [61:0] FX = 62'sd9969256628;
    localparam logic signed [61:0] CX = 62'sd5692626829;
    localparam logic signed [61:0] FY = 62'sd9916014133;
    localparam logic signed [61:0] CY = 62'sd4072484635;

    typedef struct packed {
        logic        kind;
        logic [9:0]  col;
        logic [8:0]  row;
        logic [15:0] val;
        logic        dzpos;
    } t_side;

endpackage

// ===== src/dtcr_div.sv =====
module dtcr_div
    import dtcr_pkg::*;
(
    input  logic                     i_clk,
    input  logic [DIV_NW-1:0]        i_num,
    input  logic [DIV_DW-1:0]        i_den,
    input  logic                     i_neg,
    output logic signed [DIV_QW-1:0] o_quot
);

    localparam int WW = DIV_NW + DIV_QW + 4;

    logic [DIV_NW-1:0] r_rem [0:DIV_QW];
    logic [DIV_QW-1:0] r_q   [0:DIV_QW];
    logic [DIV_DW-1:0] r_den [0:DIV_QW];
    logic              r_neg [0:DIV_QW];
    logic              r_ovf [0:DIV_QW];
    logic signed [DIV_QW-1:0] r_quot;

    // capture; a quotient that needs more bits than we produce saturates
    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
        r_neg[0] <= i_neg;
        r_q[0]   <= '0;
        r_ovf[0] <= WW'(i_num) >= (WW'(i_den) << DIV_QW);
    end

    // one restoring step per stage, most significant quotient bit first
    for (genvar k = 1; k <= DIV_QW; k++) begin : g_step
        logic [WW-1:0] w_sub;
        logic          w_fit;
        assign w_sub = WW'(r_den[k-1]) << (DIV_QW - k);
        assign w_fit = WW'(r_rem[k-1]) >= w_sub;
        always_ff @(posedge i_clk) begin
            r_den[k] <= r_den[k-1];
            r_neg[k] <= r_neg[k-1];
            r_ovf[k] <= r_ovf[k-1];
            r_q[k]   <= r_q[k-1] | (DIV_QW'(w_fit) << (DIV_QW - k));
            if (w_fit) begin
                r_rem[k] <= DIV_NW'(WW'(r_rem[k-1]) - w_sub);
            end else begin
                r_rem[k] <= r_rem[k-1];
            end
        end
    end

    // apply sign and clamp to the signed result range
    always_ff @(posedge i_clk) begin
        if (r_ovf[DIV_QW]) begin
            r_quot <= r_neg[DIV_QW] ? {1'b1, {(DIV_QW-1){1'b0}}} : {1'b0, {(DIV_QW-1){1'b1}}};
        end else if (r_neg[DIV_QW]) begin
            if (r_q[DIV_QW] > {1'b1, {(DIV_QW-1){1'b0}}}) begin
                r_quot <= {1'b1, {(DIV_QW-1){1'b0}}};
            end else begin
                r_quot <= -$signed(r_q[DIV_QW]);
            end
        end else begin
            if (r_q[DIV_QW][DIV_QW-1]) begin
                r_quot <= {1'b0, {(DIV_QW-1){1'b1}}};
            end else begin
                r_quot <= $signed(r_q[DIV_QW]);
            end
        end
    end

    assign o_quot = r_quot;

endmodule

// ===== src/depth_to_color_registration_core.sv =====
// Channel  | Direction | Handshake                     | Payload
// item in  | input     | start & !busy at clock edge   | i_kind, i_pixel_col, i_pixel_row,
//          |           |                               | i_sample_value
// result   | output    | o_valid, one cycle, no stall  | o_registered_depth, o_mapped_col,
//          |           |                               | o_mapped_row, o_in_frame
// config   | input     | i_cfg_valid & o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One item is taken every clock; busy stays low. A query result passes 26 register stages,
// the first loaded at the accepting edge. The stages are the six mapping stages, the
// 18-stage divider (capture, one stage per quotient bit, clamp) and the address and frame
// store read stages. Writes travel the same pipeline, so frame store accesses keep item order.
// Reset clears the pipeline valid bits and loads 640 x 480; the frame store is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module depth_to_color_registration_core
    import dtcr_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_kind,
    input  logic [9:0]         i_pixel_col,
    input  logic [8:0]         i_pixel_row,
    input  logic [15:0]        i_sample_value,
    output logic               o_valid,
    output logic [15:0]        o_registered_depth,
    output logic signed [15:0] o_mapped_col,
    output logic signed [15:0] o_mapped_row,
    output logic               o_in_frame,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_IW-1:0]  i_cfg_index,
    input  logic [10:0]        i_cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    // stages A..F ahead of the divider, then the divider itself
    localparam int NS    = 6 + DIV_LAT;

    logic [10:0] r_width;
    logic [9:0]  r_height;

    // Configuration: always ready; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd640;
            r_height <= 10'd480;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    // Side-band pipeline: item kind, position and sample follow the arithmetic
    logic  r_vld  [0:NS-1];
    t_side r_side [0:NS-1];
    t_side n_side3;

    // mark the point in front of the camera once dz is known
    always_comb begin
        n_side3       = r_side[2];
        n_side3.dzpos = r_c_dz > 26'sd0;
    end

    // A: color ray from pixel position
    logic signed [25:0] r_a_rx, r_a_ry;
    // B: pose products
    logic signed [51:0] r_b_x1, r_b_x2, r_b_y1, r_b_y2, r_b_z1, r_b_z2;
    // C: depth-camera point, Q.24
    logic signed [51:0] w_c_sx, w_c_sy, w_c_sz;
    logic signed [25:0] r_c_dx, r_c_dy, r_c_dz;
    // D: intrinsic products
    logic signed [61:0] r_d_fx, r_d_cx, r_d_fy, r_d_cy;
    logic signed [25:0] r_d_dz;
    // E: projection numerators
    logic signed [61:0] r_e_nc, r_e_nr;
    logic signed [25:0] r_e_dz;
    // F: divider operands
    logic [61:0]        w_f_mc, w_f_mr;
    logic [62:0]        w_f_tc, w_f_tr;
    logic [DIV_NW-1:0]  r_f_nc, r_f_nr;
    logic [DIV_DW-1:0]  r_f_den;
    logic               r_f_negc, r_f_negr;

    assign w_c_sx = r_b_x1 + r_b_x2 + PX_OFS;
    assign w_c_sy = r_b_y1 + r_b_y2 + PY_OFS;
    assign w_c_sz = r_b_z1 + r_b_z2 + PZ_OFS;

    assign w_f_mc = r_e_nc[61] ? 62'(-r_e_nc) : 62'(r_e_nc);
    assign w_f_mr = r_e_nr[61] ? 62'(-r_e_nr) : 62'(r_e_nr);
    // 2*|num| + dz*2^24, then drop the 2^25 common to both sides of the divide
    assign w_f_tc = {w_f_mc, 1'b0} + (63'(unsigned'(r_e_dz)) << 24);
    assign w_f_tr = {w_f_mr, 1'b0} + (63'(unsigned'(r_e_dz)) << 24);

    always_ff @(posedge i_clk) begin
        // A
        r_a_rx <= K11 * 26'(i_pixel_col) + K13;
        r_a_ry <= K22 * 26'(i_pixel_row) + K23;
        // B
        r_b_x1 <= 52'(P11) * 52'(r_a_rx);
        r_b_x2 <= 52'(P12) * 52'(r_a_ry);
        r_b_y1 <= 52'(P21) * 52'(r_a_rx);
        r_b_y2 <= 52'(P22) * 52'(r_a_ry);
        r_b_z1 <= 52'(P31) * 52'(r_a_rx);
        r_b_z2 <= 52'(P32) * 52'(r_a_ry);
        // C: floor shift by 24
        r_c_dx <= w_c_sx[49:24];
        r_c_dy <= w_c_sy[49:24];
        r_c_dz <= w_c_sz[49:24];
        // D
        r_d_fx <= FX * 62'(r_c_dx);
        r_d_cx <= CX * 62'(r_c_dz);
        r_d_fy <= FY * 62'(r_c_dy);
        r_d_cy <= CY * 62'(r_c_dz);
        r_d_dz <= r_c_dz;
        // E
        r_e_nc <= r_d_fx + r_d_cx;
        r_e_nr <= r_d_fy + r_d_cy;
        r_e_dz <= r_d_dz;
        // F
        r_f_nc   <= w_f_tc[62:25];
        r_f_nr   <= w_f_tr[62:25];
        r_f_den  <= DIV_DW'(unsigned'(r_e_dz));
        r_f_negc <= r_e_nc[61];
        r_f_negr <= r_e_nr[61];
    end

    // Advance the side-band
    always_ff @(posedge i_clk) begin
        r_side[0] <= '{kind: i_kind, col: i_pixel_col, row: i_pixel_row,
                       val: i_sample_value, dzpos: 1'b0};
        r_side[1] <= r_side[0];
        r_side[2] <= r_side[1];
        r_side[3] <= n_side3;
        for (int i = 4; i < NS; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start;
            for (int i = 1; i < NS; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    logic signed [15:0] w_qc, w_qr;

    dtcr_div u_div_col (
        .i_clk  (i_clk),
        .i_num  (r_f_nc),
        .i_den  (r_f_den),
        .i_neg  (r_f_negc),
        .o_quot (w_qc)
    );

    dtcr_div u_div_row (
        .i_clk  (i_clk),
        .i_num  (r_f_nr),
        .i_den  (r_f_den),
        .i_neg  (r_f_negr),
        .o_quot (w_qr)
    );

    // G: frame test and store address
    t_side              w_g_sd;
    logic signed [15:0] w_g_mc, w_g_mr;
    logic               w_g_in, w_g_we;
    logic [AW-1:0]      w_g_addr;

    logic               r_g_vld, r_g_query, r_g_we, r_g_in;
    logic [AW-1:0]      r_g_addr;
    logic [15:0]        r_g_val;
    logic signed [15:0] r_g_mc, r_g_mr;

    always_comb begin
        w_g_sd = r_side[NS-1];
        w_g_mc = w_g_sd.dzpos ? w_qc : 16'sd0;
        w_g_mr = w_g_sd.dzpos ? w_qr : 16'sd0;
        w_g_in = w_g_sd.dzpos && !w_g_mc[15] && !w_g_mr[15]
              && (unsigned'(w_g_mc) < 16'(r_width))
              && (unsigned'(w_g_mc) < 16'(MAX_WIDTH))
              && (unsigned'(w_g_mr) < 16'(r_height))
              && (unsigned'(w_g_mr) < 16'(MAX_HEIGHT));
        // drop writes that fall outside the store
        w_g_we = r_vld[NS-1] && (w_g_sd.kind == KIND_WRITE)
              && (32'(w_g_sd.col) < MAX_WIDTH) && (32'(w_g_sd.row) < MAX_HEIGHT);
        if (w_g_sd.kind == KIND_WRITE) begin
            w_g_addr = AW'(w_g_sd.row) * AW'(MAX_WIDTH) + AW'(w_g_sd.col);
        end else begin
            w_g_addr = AW'(unsigned'(w_g_mr)) * AW'(MAX_WIDTH) + AW'(unsigned'(w_g_mc));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
            r_g_we  <= 1'b0;
        end else begin
            r_g_vld <= r_vld[NS-1];
            r_g_we  <= w_g_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_query <= w_g_sd.kind == KIND_QUERY;
        r_g_in    <= w_g_in;
        r_g_addr  <= w_g_addr;
        r_g_val   <= w_g_sd.val;
        r_g_mc    <= w_g_mc;
        r_g_mr    <= w_g_mr;
    end

    // H: frame store, one access per item in item order
    logic [15:0] r_mem [0:DEPTH-1];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (r_g_we) begin
            r_mem[r_g_addr] <= r_g_val;
        end
        r_rdata <= r_mem[r_g_addr];
    end

    logic               r_h_vld, r_h_in;
    logic signed [15:0] r_h_mc, r_h_mr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else begin
            r_h_vld <= r_g_vld && r_g_query;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_in <= r_g_in;
        r_h_mc <= r_g_mc;
        r_h_mr <= r_g_mr;
    end

    assign o_valid            = r_h_vld;
    assign o_registered_depth = r_h_in ? r_rdata : 16'd0;
    assign o_mapped_col       = r_h_mc;
    assign o_mapped_row       = r_h_mr;
    assign o_in_frame         = r_h_in;

endmodule
